// ===== src/gscs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gscs_pkg
// Shared types and constants of the gas sensor heater cycle sampler.
// ----------------------------------------------------------------------------
package gscs_pkg;

	localparam int BURST_LEN   = 32;
	localparam int SAMPLE_BITS = 12;
	localparam int TIMER_BITS  = 24;

	localparam int CFG_W       = 24;
	localparam int DUTY_W      = 8;
	localparam int SAMPLE_W    = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int AVG_SHIFT   = 5;

	localparam int CNT_W = $clog2(BURST_LEN + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(BURST_LEN);
	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int SAT_W = (SUM_W > SAMPLE_BITS) ? SUM_W : SAMPLE_BITS;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
	localparam logic [DUTY_W-1:0]     FULL_DUTY = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_HEAT_TICKS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_DUTY  = 2'd3;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic                operation;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]   heater_duty;
		logic                phase;
		logic                sample_request;
		logic                average_valid;
		logic [SAMPLE_W-1:0] average;
		logic                warmed_up;
	} result_t;

endpackage

// ===== src/gscs_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gscs_item_if
// Input channel: valid/ready handshake carrying one tick or sample item.
// ----------------------------------------------------------------------------
interface gscs_item_if;
	logic            valid;
	logic            ready;
	gscs_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/gscs_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gscs_result_if
// Output channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface gscs_result_if;
	logic              valid;
	logic              ready;
	gscs_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/gas_sensor_heater_cycle_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_heater_cycle_sampler
// Heater phase sequencer with timed sample bursts and burst averaging.
//
//   channel   dir   payload                                   transfer when
//   item      in    operation, sample                         valid && ready
//   result    out   heater_duty, phase, sample_request,       valid && ready
//                   average_valid, average, warmed_up
//   cfg       in    cfg_index, cfg_wdata                      cfg_we
//
// One item per cycle while item.ready is high; results leave in item order.
// State updates at the item transfer; the result goes to an output register
// backed by a one-entry skid register, so item.ready drops only when both
// are full. Reset loads the register defaults and clears all phase state;
// no clearing pass.
// ----------------------------------------------------------------------------
module gas_sensor_heater_cycle_sampler (
	input  logic                             clk,
	input  logic                             arst_n,
	gscs_item_if.sink                        item,
	gscs_result_if.source                    result,
	input  logic                             cfg_we,
	input  logic [gscs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gscs_pkg::CFG_W-1:0]       cfg_wdata
);

	typedef struct packed {
		logic                                 measuring;
		logic [gscs_pkg::TIMER_BITS-1:0]      phase_ticks;
		logic [gscs_pkg::TIMER_BITS-1:0]      ticks_since_read;
		logic                                 burst_active;
		logic [gscs_pkg::CNT_W-1:0]           burst_count;
		logic [gscs_pkg::SUM_W-1:0]           burst_sum;
		logic                                 ready;
	} state_t;

	localparam logic [gscs_pkg::SAMPLE_W-1:0] SAMPLE_IN_MASK =
		gscs_pkg::SAMPLE_W'((64'd1 << gscs_pkg::SAMPLE_BITS) - 64'd1);
	localparam logic [gscs_pkg::SAT_W-1:0] AVG_MAX =
		gscs_pkg::SAT_W'((64'd1 << gscs_pkg::SAMPLE_BITS) - 64'd1);

	function automatic logic [gscs_pkg::TIMER_BITS-1:0] sat_inc(
		input logic [gscs_pkg::TIMER_BITS-1:0] t
	);
		return (t == gscs_pkg::TIMER_MAX) ? t : t + 1'b1;
	endfunction

	function automatic logic reached(
		input logic [gscs_pkg::TIMER_BITS-1:0] t,
		input logic [gscs_pkg::CFG_W-1:0]      limit
	);
		return (gscs_pkg::CMP_W'(t) >= gscs_pkg::CMP_W'(limit)) ||
			(t == gscs_pkg::TIMER_MAX);
	endfunction

	logic [gscs_pkg::CFG_W-1:0]  heat_ticks_q;
	logic [gscs_pkg::CFG_W-1:0]  measure_ticks_q;
	logic [gscs_pkg::CFG_W-1:0]  read_interval_q;
	logic [gscs_pkg::DUTY_W-1:0] measure_duty_q;

	state_t            state_q;
	state_t            state_d;
	gscs_pkg::result_t res_d;
	gscs_pkg::result_t out_q;
	gscs_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              in_xfer;
	logic              out_xfer;

	logic [gscs_pkg::TIMER_BITS-1:0] pt_inc;
	logic [gscs_pkg::TIMER_BITS-1:0] tsr_inc;
	logic [gscs_pkg::SUM_W-1:0]      sum_next;
	logic [gscs_pkg::CNT_W-1:0]      cnt_next;
	logic [gscs_pkg::SAT_W-1:0]      avg_full;

	assign item.ready    = !skid_valid_q;
	assign in_xfer       = item.valid && item.ready;
	assign out_xfer      = out_valid_q && result.ready;
	assign result.valid  = out_valid_q;
	assign result.data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_ticks_q    <= 24'd60000;
			measure_ticks_q <= 24'd90000;
			read_interval_q <= 24'd5000;
			measure_duty_q  <= 8'd71;
		end else if (cfg_we) begin
			case (cfg_index)
				gscs_pkg::REG_HEAT_TICKS:    heat_ticks_q    <= cfg_wdata;
				gscs_pkg::REG_MEASURE_TICKS: measure_ticks_q <= cfg_wdata;
				gscs_pkg::REG_READ_INTERVAL: read_interval_q <= cfg_wdata;
				gscs_pkg::REG_MEASURE_DUTY:  measure_duty_q  <= cfg_wdata[gscs_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d  = state_q;
		res_d    = '0;
		pt_inc   = sat_inc(state_q.phase_ticks);
		tsr_inc  = sat_inc(state_q.ticks_since_read);
		sum_next = state_q.burst_sum +
			gscs_pkg::SUM_W'(item.data.sample & SAMPLE_IN_MASK);
		cnt_next = state_q.burst_count + 1'b1;
		avg_full = gscs_pkg::SAT_W'(sum_next >> gscs_pkg::AVG_SHIFT);

		if (item.data.operation == gscs_pkg::OP_TICK) begin
			state_d.phase_ticks      = pt_inc;
			state_d.ticks_since_read = tsr_inc;
			if (!state_q.measuring) begin
				if (reached(pt_inc, heat_ticks_q)) begin
					state_d.measuring        = 1'b1;
					state_d.phase_ticks      = '0;
					state_d.ticks_since_read = gscs_pkg::TIMER_MAX;
				end
			end else begin
				if (!state_q.burst_active && reached(tsr_inc, read_interval_q)) begin
					state_d.ticks_since_read = '0;
					state_d.burst_active     = 1'b1;
					state_d.burst_count      = '0;
					state_d.burst_sum        = '0;
					res_d.sample_request     = 1'b1;
				end
				if (reached(pt_inc, measure_ticks_q)) begin
					state_d.measuring   = 1'b0;
					state_d.phase_ticks = '0;
					state_d.ready       = 1'b1;
				end
			end
		end else if (state_q.burst_active) begin
			state_d.burst_sum   = sum_next;
			state_d.burst_count = cnt_next;
			if (gscs_pkg::CNT_W'(gscs_pkg::BURST_LEN) <= cnt_next) begin
				res_d.average_valid  = 1'b1;
				res_d.average        = (avg_full > AVG_MAX) ?
					AVG_MAX[gscs_pkg::SAMPLE_W-1:0] : avg_full[gscs_pkg::SAMPLE_W-1:0];
				state_d.burst_active = 1'b0;
				state_d.burst_count  = '0;
				state_d.burst_sum    = '0;
			end
		end

		res_d.phase        = state_d.measuring;
		res_d.heater_duty  = state_d.measuring ? measure_duty_q : gscs_pkg::FULL_DUTY;
		res_d.warmed_up    = state_d.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_xfer) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_xfer) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_xfer) begin
			if (!out_valid_q || out_xfer) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_xfer) begin
				out_q <= skid_q;
			end
		end else if (in_xfer) begin
			if (!out_valid_q || out_xfer) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end
	end

endmodule

// ===== bench/tb_gas_sensor_heater_cycle_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gas_sensor_heater_cycle_sampler
// Self-checking bench for the heater cycle sampler. A clocked driver sends
// tick and sample items from a backlog with random gaps. A clocked receiver
// stalls at random and holds off once for a long stretch. Each accepted item
// runs through a cycle-free model of the phase timers and burst averager.
// Every result is compared field by field against the model's oldest
// prediction. Phases run with low, zero, middle and saturating register
// settings.
// ----------------------------------------------------------------------------
module tb_gas_sensor_heater_cycle_sampler;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int FIELD_W     = gscs_pkg::SAMPLE_W;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [gscs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [gscs_pkg::CFG_W-1:0]     cfg_wdata;

	gscs_item_if   item_ch ();
	gscs_result_if result_ch ();

	gas_sensor_heater_cycle_sampler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// heater model state and register copies
	logic [gscs_pkg::TIMER_BITS-1:0] phase_cnt;
	logic [gscs_pkg::TIMER_BITS-1:0] read_cnt;
	logic                            meas_on;
	logic                            burst_on;
	int unsigned                     burst_n;
	logic [gscs_pkg::SUM_W-1:0]      burst_acc;
	logic                            sensor_rdy;
	logic [gscs_pkg::CFG_W-1:0]      heat_len;
	logic [gscs_pkg::CFG_W-1:0]      meas_len;
	logic [gscs_pkg::CFG_W-1:0]      read_len;
	logic [gscs_pkg::DUTY_W-1:0]     duty_meas;

	gscs_pkg::item_t   item_backlog [$];
	gscs_pkg::result_t expected_status [$];

	int unsigned errors;
	int unsigned cycle_count;
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned hold_left;
	int unsigned hold_requests;
	int unsigned hold_served;
	bit          steady;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [gscs_pkg::TIMER_BITS-1:0] bump(
			logic [gscs_pkg::TIMER_BITS-1:0] t);
		return (t == gscs_pkg::TIMER_MAX) ? gscs_pkg::TIMER_MAX : t + 1'b1;
	endfunction

	function automatic logic hit(logic [gscs_pkg::TIMER_BITS-1:0] t,
			logic [gscs_pkg::CFG_W-1:0] limit);
		return (t >= limit) || (t == gscs_pkg::TIMER_MAX);
	endfunction

	function automatic gscs_pkg::item_t make_item(logic op,
			logic [gscs_pkg::SAMPLE_W-1:0] s);
		gscs_pkg::item_t it;
		it.operation = op;
		it.sample = s;
		return it;
	endfunction

	function automatic gscs_pkg::result_t advance_heater(gscs_pkg::item_t it);
		gscs_pkg::result_t          r;
		logic [gscs_pkg::SUM_W-1:0] avg_full;
		r = '0;
		if (it.operation == gscs_pkg::OP_TICK) begin
			phase_cnt = bump(phase_cnt);
			read_cnt = bump(read_cnt);
			if (!meas_on) begin
				if (hit(phase_cnt, heat_len)) begin
					meas_on = 1'b1;
					phase_cnt = '0;
					read_cnt = gscs_pkg::TIMER_MAX;
				end
			end else begin
				if (!burst_on && hit(read_cnt, read_len)) begin
					read_cnt = '0;
					burst_on = 1'b1;
					burst_n = 0;
					burst_acc = '0;
					r.sample_request = 1'b1;
				end
				if (hit(phase_cnt, meas_len)) begin
					meas_on = 1'b0;
					phase_cnt = '0;
					sensor_rdy = 1'b1;
				end
			end
		end else if (burst_on) begin
			burst_acc = burst_acc + gscs_pkg::SUM_W'(it.sample);
			burst_n++;
			if (burst_n >= gscs_pkg::BURST_LEN) begin
				avg_full = burst_acc >> gscs_pkg::AVG_SHIFT;
				if (avg_full > {gscs_pkg::SAMPLE_BITS{1'b1}})
					avg_full = {gscs_pkg::SAMPLE_BITS{1'b1}};
				r.average = avg_full[gscs_pkg::SAMPLE_W-1:0];
				r.average_valid = 1'b1;
				burst_on = 1'b0;
				burst_n = 0;
				burst_acc = '0;
			end
		end
		r.heater_duty = meas_on ? duty_meas : gscs_pkg::FULL_DUTY;
		r.phase = meas_on;
		r.warmed_up = sensor_rdy;
		return r;
	endfunction

	task automatic check_field(string name, logic [FIELD_W-1:0] exp_v,
			logic [FIELD_W-1:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endtask

	task automatic write_reg(logic [gscs_pkg::CFG_IDX_W-1:0] idx,
			logic [gscs_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			gscs_pkg::REG_HEAT_TICKS:    heat_len = val;
			gscs_pkg::REG_MEASURE_TICKS: meas_len = val;
			gscs_pkg::REG_READ_INTERVAL: read_len = val;
			gscs_pkg::REG_MEASURE_DUTY:  duty_meas = val[gscs_pkg::DUTY_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(logic [gscs_pkg::CFG_W-1:0] heat,
			logic [gscs_pkg::CFG_W-1:0] meas,
			logic [gscs_pkg::CFG_W-1:0] intv, logic [gscs_pkg::CFG_W-1:0] duty);
		write_reg(gscs_pkg::REG_HEAT_TICKS, heat);
		write_reg(gscs_pkg::REG_MEASURE_TICKS, meas);
		write_reg(gscs_pkg::REG_READ_INTERVAL, intv);
		write_reg(gscs_pkg::REG_MEASURE_DUTY, duty);
	endtask

	task automatic drain();
		while (item_backlog.size() != 0 || item_ch.valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly a few ticks and a full burst; some short runs of ticks, broken bursts, noise
	task automatic queue_random(int unsigned count);
		int unsigned added;
		int unsigned r;
		int unsigned n;
		int unsigned fill;
		logic [gscs_pkg::SAMPLE_W-1:0] s;
		added = 0;
		while (added < count) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				n = $urandom_range(1, 4);
				repeat (n) item_backlog.push_back(make_item(gscs_pkg::OP_TICK, '0));
				fill = $urandom_range(0, 3);
				n = ($urandom_range(0, 9) == 0) ?
					$urandom_range(1, gscs_pkg::BURST_LEN - 1) : gscs_pkg::BURST_LEN;
				for (int k = 0; k < n; k++) begin
					case (fill)
						0: s = gscs_pkg::SAMPLE_W'($urandom_range(0, 4095));
						1: s = '1;
						2: s = '0;
						default: s = k[0] ? 12'h555 : 12'hAAA;
					endcase
					item_backlog.push_back(make_item(gscs_pkg::OP_SAMPLE, s));
				end
				added += n + 1;
			end else if (r < 80) begin
				n = $urandom_range(1, 12);
				repeat (n) item_backlog.push_back(make_item(gscs_pkg::OP_TICK, '0));
				added += n;
			end else begin
				n = $urandom_range(1, 6);
				repeat (n)
					item_backlog.push_back(make_item(1'($urandom_range(0, 1)),
						gscs_pkg::SAMPLE_W'($urandom_range(0, 4095))));
				added += n;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("gas_sensor_heater_cycle_sampler: mismatch");
			$finish;
		end
	end

	// sender: hold data until transfer, then advance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data <= '0;
			send_gap = 0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				item_ch.valid <= 1'b0;
			end else if (item_backlog.size() > 0) begin
				item_ch.data <= item_backlog.pop_front();
				item_ch.valid <= 1'b1;
				if (!steady && $urandom_range(0, 99) < 25)
					send_gap = pick_gap();
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (!steady && $urandom_range(0, 99) < 20)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready)
			expected_status.push_back(advance_heater(item_ch.data));
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t ns: result with nothing expected, got %h", $time,
					result_ch.data);
			end else begin
				gscs_pkg::result_t want;
				want = expected_status.pop_front();
				check_field("heater_duty", FIELD_W'(want.heater_duty),
					FIELD_W'(result_ch.data.heater_duty));
				check_field("phase", FIELD_W'(want.phase), FIELD_W'(result_ch.data.phase));
				check_field("sample_request", FIELD_W'(want.sample_request),
					FIELD_W'(result_ch.data.sample_request));
				check_field("average_valid", FIELD_W'(want.average_valid),
					FIELD_W'(result_ch.data.average_valid));
				check_field("average", want.average, result_ch.data.average);
				check_field("warmed_up", FIELD_W'(want.warmed_up),
					FIELD_W'(result_ch.data.warmed_up));
			end
		end
	end

	initial begin
		errors = 0;
		cycle_count = 0;
		hold_requests = 0;
		hold_served = 0;
		steady = 1'b0;
		phase_cnt = '0;
		read_cnt = '0;
		meas_on = 1'b0;
		burst_on = 1'b0;
		burst_n = 0;
		burst_acc = '0;
		sensor_rdy = 1'b0;
		heat_len = 24'd60000;
		meas_len = 24'd90000;
		read_len = 24'd5000;
		duty_meas = 8'd71;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= gscs_pkg::REG_HEAT_TICKS;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// short heating, other registers at reset values; stray samples first
		write_reg(gscs_pkg::REG_HEAT_TICKS, 24'd3);
		item_backlog.push_back(make_item(gscs_pkg::OP_SAMPLE, 12'hFFF));
		item_backlog.push_back(make_item(gscs_pkg::OP_SAMPLE, 12'h000));
		repeat (5) item_backlog.push_back(make_item(gscs_pkg::OP_TICK, '0));
		item_backlog.push_back(make_item(gscs_pkg::OP_SAMPLE, 12'hAAA));
		item_backlog.push_back(make_item(gscs_pkg::OP_SAMPLE, 12'h555));
		item_backlog.push_back(make_item(gscs_pkg::OP_SAMPLE, 12'hFFF));
		item_backlog.push_back(make_item(gscs_pkg::OP_SAMPLE, 12'h000));
		item_backlog.push_back(make_item(gscs_pkg::OP_TICK, '0));
		drain();

		set_regs(24'd1, 24'd1, 24'd1, 24'd0);
		queue_random(160);
		drain();

		set_regs(24'd0, 24'd0, 24'd0, 24'd255);
		queue_random(160);
		drain();

		// no idling; receiver holds off so the block backs up
		set_regs(24'd4, 24'd60, 24'd8, gscs_pkg::CFG_W'($urandom_range(0, 255)));
		steady = 1'b1;
		queue_random(170);
		hold_requests++;
		drain();
		steady = 1'b0;

		set_regs(gscs_pkg::CFG_W'($urandom_range(1, 6)),
			gscs_pkg::CFG_W'($urandom_range(5, 80)),
			gscs_pkg::CFG_W'($urandom_range(1, 40)),
			gscs_pkg::CFG_W'($urandom_range(0, 255)));
		queue_random(160);
		drain();

		set_regs(24'd2, 24'hFFFFFF, 24'hFFFFFF, 24'd71);
		queue_random(140);
		drain();

		set_regs(24'hFFFFFF, 24'd3, 24'd2, 24'd200);
		queue_random(160);
		drain();

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("gas_sensor_heater_cycle_sampler: match");
		else
			$display("gas_sensor_heater_cycle_sampler: mismatch");
		$finish;
	end
endmodule

// ===== gas_sensor_heater_cycle_sampler.f =====
src/gscs_pkg.sv
src/gscs_item_if.sv
src/gscs_result_if.sv
src/gas_sensor_heater_cycle_sampler.sv
bench/tb_gas_sensor_heater_cycle_sampler.sv
